// File: rtl/tftp_pkg.sv
// ----------------------------------------------------------------------------
// tftp_pkg: shared types and constants for the TFTP read transfer sender
// Phase, operation and action codes, item and state structs, fixed limits.
// ----------------------------------------------------------------------------
package tftp_pkg;

	// Largest data block in bytes, and the saturation bound of block_length
	localparam int unsigned BLOCK_BYTES = 512;
	localparam logic [16:0] BLOCK_BYTES_W = 17'(BLOCK_BYTES);
	localparam logic [9:0] LEN_CAP = (BLOCK_BYTES < 1023) ? 10'(BLOCK_BYTES) : 10'd1023;

	// Configuration register defaults and indexes
	localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd50;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;
	localparam logic        CFG_RETRY_LIMIT   = 1'b0;
	localparam logic        CFG_TIMEOUT_TICKS = 1'b1;

	// Protocol constants
	localparam logic [15:0] OPC_ACK       = 16'd4;
	localparam logic [9:0]  ACK_LEN       = 10'd4;
	localparam logic [2:0]  ERR_NOT_FOUND = 3'd1;
	localparam logic [2:0]  ERR_BAD_MODE  = 3'd0;
	localparam logic [2:0]  ERR_NONE      = 3'd0;

	// Result actions
	localparam logic [2:0] ACT_DATA     = 3'd0;
	localparam logic [2:0] ACT_ERROR    = 3'd1;
	localparam logic [2:0] ACT_REQUEST  = 3'd2;
	localparam logic [2:0] ACT_COMPLETE = 3'd3;
	localparam logic [2:0] ACT_TIMEOUT  = 3'd4;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_BLOCK  = 2'd1,
		OP_PACKET = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE       = 2'd0,
		PH_WAIT_BLOCK = 2'd1,
		PH_WAIT_ACK   = 2'd2
	} phase_t;

	typedef struct packed {
		op_t         op;
		logic        file_found;
		logic        mode_known;
		logic [9:0]  block_length;
		logic [9:0]  packet_length;
		logic [15:0] packet_opcode;
		logic [15:0] packet_block;
	} item_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] blk;
		logic [9:0]  len;
		logic [7:0]  attempts;
		logic [15:0] elapsed;
	} xfer_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  action;
		logic [15:0] blk;
		logic [9:0]  len;
		logic [2:0]  err;
	} res_t;

endpackage

// File: rtl/tftp_step.sv
// ----------------------------------------------------------------------------
// tftp_step: transfer update for one item
// Combinational next-state and result logic for the stop-and-wait sender.
// ----------------------------------------------------------------------------
module tftp_step (
	input  tftp_pkg::item_t item,
	input  tftp_pkg::xfer_t cur,
	input  logic [7:0]      retry_limit,
	input  logic [15:0]     timeout_ticks,
	output tftp_pkg::xfer_t nxt,
	output tftp_pkg::res_t  res
);

	logic [15:0] elapsed_inc;
	logic        ack_match;
	logic        short_block;
	logic        busy;

	assign elapsed_inc = cur.elapsed + 16'd1;
	assign ack_match   = (item.packet_length == tftp_pkg::ACK_LEN)
		&& (item.packet_opcode == tftp_pkg::OPC_ACK)
		&& (item.packet_block == cur.blk);
	assign short_block = {7'b0, cur.len} < tftp_pkg::BLOCK_BYTES_W;
	assign busy = (cur.phase == tftp_pkg::PH_WAIT_BLOCK) || (cur.phase == tftp_pkg::PH_WAIT_ACK);

	always_comb begin
		nxt        = cur;
		res.valid  = 1'b0;
		res.action = tftp_pkg::ACT_DATA;
		res.blk    = cur.blk;
		res.len    = cur.len;
		res.err    = tftp_pkg::ERR_NONE;
		unique case (item.op)
			tftp_pkg::OP_START: begin
				if (!busy) begin
					res.valid = 1'b1;
					if (!item.file_found || !item.mode_known) begin
						res.action = tftp_pkg::ACT_ERROR;
						res.blk    = '0;
						res.len    = '0;
						res.err    = item.file_found ? tftp_pkg::ERR_BAD_MODE
							: tftp_pkg::ERR_NOT_FOUND;
					end else begin
						nxt.phase    = tftp_pkg::PH_WAIT_BLOCK;
						nxt.blk      = '0;
						nxt.len      = '0;
						nxt.attempts = '0;
						nxt.elapsed  = '0;
						res.action   = tftp_pkg::ACT_REQUEST;
						res.blk      = '0;
						res.len      = '0;
					end
				end
			end
			tftp_pkg::OP_BLOCK: begin
				if (cur.phase == tftp_pkg::PH_WAIT_BLOCK) begin
					nxt.phase    = tftp_pkg::PH_WAIT_ACK;
					nxt.blk      = cur.blk + 16'd1;
					nxt.len      = (item.block_length > tftp_pkg::LEN_CAP) ? tftp_pkg::LEN_CAP
						: item.block_length;
					nxt.attempts = 8'd1;
					nxt.elapsed  = '0;
					res.valid    = 1'b1;
					res.action   = tftp_pkg::ACT_DATA;
					res.blk      = nxt.blk;
					res.len      = nxt.len;
				end
			end
			tftp_pkg::OP_PACKET: begin
				if (cur.phase == tftp_pkg::PH_WAIT_ACK && ack_match) begin
					nxt.elapsed = '0;
					res.valid   = 1'b1;
					if (short_block) begin
						nxt.phase  = tftp_pkg::PH_IDLE;
						res.action = tftp_pkg::ACT_COMPLETE;
					end else begin
						nxt.phase  = tftp_pkg::PH_WAIT_BLOCK;
						res.action = tftp_pkg::ACT_REQUEST;
					end
				end
			end
			tftp_pkg::OP_TICK: begin
				if (cur.phase == tftp_pkg::PH_WAIT_ACK) begin
					if (elapsed_inc < timeout_ticks) begin
						nxt.elapsed = elapsed_inc;
					end else begin
						nxt.elapsed = '0;
						res.valid   = 1'b1;
						if (cur.attempts >= retry_limit) begin
							nxt.phase  = tftp_pkg::PH_IDLE;
							res.action = tftp_pkg::ACT_TIMEOUT;
						end else begin
							nxt.attempts = cur.attempts + 8'd1;
							res.action   = tftp_pkg::ACT_DATA;
						end
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// File: rtl/tftp_read_transfer_sender_unit.sv
// ----------------------------------------------------------------------------
// tftp_read_transfer_sender_unit: stop-and-wait TFTP read transfer sender
// Path: an item is held in the input register s1, and its result is registered
// in the output register s2. Throughput: one item per cycle unless a result waits
// on a full output slot, set by the combinational transfer state update.
// Reset: async active low; phase idle, counters zero, retry 50, timeout 100.
// ----------------------------------------------------------------------------
module tftp_read_transfer_sender_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic        file_found,
	input  logic        mode_known,
	input  logic [9:0]  block_length,
	input  logic [9:0]  packet_length,
	input  logic [15:0] packet_opcode,
	input  logic [15:0] packet_block,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [15:0] block_number,
	output logic [9:0]  data_length,
	output logic [2:0]  error_code
);

	// configuration registers
	logic [7:0]  retry_limit_q;
	logic [15:0] timeout_ticks_q;

	// input register
	logic            valid_s1;
	tftp_pkg::item_t item_s1;

	// transfer state
	tftp_pkg::xfer_t xfer_q;
	tftp_pkg::xfer_t xfer_nxt;
	tftp_pkg::res_t  res;

	// output register
	logic            valid_s2;
	tftp_pkg::res_t  res_s2;

	logic advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q   <= tftp_pkg::RETRY_LIMIT_RST;
			timeout_ticks_q <= tftp_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			if (cfg_index == tftp_pkg::CFG_RETRY_LIMIT) begin
				retry_limit_q <= cfg_data[7:0];
			end else begin
				timeout_ticks_q <= cfg_data;
			end
		end
	end

	// The staged item moves on when the output slot is free or it yields no
	// result; the input side refills s1 in the same cycle.
	assign advance  = valid_s1 && (!res.valid || !valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.op            <= tftp_pkg::op_t'(operation);
			item_s1.file_found    <= file_found;
			item_s1.mode_known    <= mode_known;
			item_s1.block_length  <= block_length;
			item_s1.packet_length <= packet_length;
			item_s1.packet_opcode <= packet_opcode;
			item_s1.packet_block  <= packet_block;
		end
	end

	tftp_step u_step (
		.item          (item_s1),
		.cur           (xfer_q),
		.retry_limit   (retry_limit_q),
		.timeout_ticks (timeout_ticks_q),
		.nxt           (xfer_nxt),
		.res           (res)
	);

	// state commits only when the item actually leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xfer_q <= '{phase: tftp_pkg::PH_IDLE, blk: '0, len: '0, attempts: '0, elapsed: '0};
		end else if (advance) begin
			xfer_q <= xfer_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res.valid) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign action       = res_s2.action;
	assign block_number = res_s2.blk;
	assign data_length  = res_s2.len;
	assign error_code   = res_s2.err;

`ifndef SYNTHESIS
	// error results never carry a block header
	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.action == tftp_pkg::ACT_ERROR)
		|-> (res_s2.blk == '0 && res_s2.len == '0))
		else $error("error item carries block fields");

	// at least one send attempt is counted while waiting for an ACK
	a_attempts_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer_q.phase == tftp_pkg::PH_WAIT_ACK) |-> (xfer_q.attempts != '0))
		else $error("awaiting ACK with zero attempts");

	// a staged item that cannot move on is kept
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("staged item lost while stalled");
`endif

endmodule
